@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition this cycle implies consequence next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/fxlms_pkg.sv @@
// shared types, constants and helper functions of the narrowband fxlms controller
`timescale 1ns / 1ps
package fxlms_pkg;

    localparam int SIG_W  = 24;           // q20 signal width
    localparam int WGT_W  = 32;           // q24 weight width
    localparam int MUL_W  = 33;           // shared multiplier operand width
    localparam int PROD_W = 2 * MUL_W;    // multiplier product width
    localparam int NRM_W  = 48;           // norm width
    localparam int DVD_W  = 63;           // dividend magnitude width
    localparam int RAT_W  = 40;           // saturated ratio width

    localparam logic [30:0] SIN_A = 31'd1686629713;
    localparam logic [30:0] SIN_B = 31'd688904866;
    localparam logic [30:0] SIN_C = 31'd76016977;

    localparam logic [38:0] RATIO_LIM = 39'h40_0000_0000;
    localparam logic signed [WGT_W-1:0] WS_RESET = 32'sd83886;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_AMP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_PHASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_START = 3'd4;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    function automatic logic signed [SIG_W-1:0] sat_s24(input logic signed [63:0] v);
        if (v > 64'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -64'sd8388608) begin
            return 24'sh800000;
        end
        return v[SIG_W-1:0];
    endfunction

    function automatic logic signed [WGT_W-1:0] sat_s32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[WGT_W-1:0];
    endfunction

    // add half an lsb, then arithmetic shift
    function automatic logic signed [63:0] round_shr(input logic signed [63:0] v,
                                                     input int sh);
        logic signed [63:0] half;
        half = 64'sd1 <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

endpackage

@@ hw/rtl/fxlms_mul.sv @@
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module fxlms_mul import fxlms_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ hw/rtl/fxlms_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fxlms_div import fxlms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [NRM_W-1:0]  i_divisor,
    output logic [DVD_W-1:0]  o_quot,
    output t_div_status       o_stat
);

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NRM_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [NRM_W-1:0] r_div;

    logic [NRM_W:0] trial;
    logic [NRM_W:0] diff;
    logic           ge;

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? diff[NRM_W-1:0] : trial[NRM_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], ge};
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_quot      = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    `ASSERT_CLK(a_div_no_restart, i_clk, i_rst_n, i_start |-> !r_busy, "start while busy")
    `ASSERT_CLK(a_div_done_end, i_clk, i_rst_n, r_done |-> (!r_busy && $past(r_busy)), "stray done")
    `ASSERT_NEXT(a_div_run, i_clk, i_rst_n, r_busy && (r_cnt != LAST) && !i_start, r_busy, "divider stopped early")

endmodule

@@ hw/rtl/narrowband_fxlms_controller_unit.sv @@
// top level of the narrowband filtered-x lms controller: sequencer, tables and state
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  -----------------------------------
//  in        in         i_in_valid / o_in_stall      i_action i_feedback i_coef_index
//                                                    i_coef_value
//  out       out        o_out_valid / i_out_stall    o_drive o_error_value o_adapting
//  cfg       in         i_cfg_we                     i_cfg_index i_cfg_data
//
//  an in-range coefficient load word is written to the table from idle; a tick runs
//  the sequencer through its states, paced by the single shared multiplier (two
//  products per tap) and, with adaptation, by a divider wait per weight
//  after reset a clearing pass over all TAPS entries zeroes both tables; input is
//  stalled meanwhile, config writes are taken as ever
//  input is stalled whenever the sequencer is busy; a finished result sits in the
//  output register and the next word may be accepted while it waits
module narrowband_fxlms_controller_unit import fxlms_pkg::*; #(
    parameter int TAPS = 300
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]             i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_action,
    input  logic signed [SIG_W-1:0] i_feedback,
    input  logic [8:0]              i_coef_index,
    input  logic signed [SIG_W-1:0] i_coef_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [SIG_W-1:0] o_drive,
    output logic signed [SIG_W-1:0] o_error_value,
    output logic                    o_adapting
);

    localparam int ADDR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W  = 2 * SIG_W + ADDR_W + 1;
    localparam logic [ADDR_W-1:0] LAST_TAP = ADDR_W'(TAPS - 1);

    localparam logic [1:0] SEL_SIN  = 2'd0;
    localparam logic [1:0] SEL_COS  = 2'd1;
    localparam logic [1:0] SEL_GOAL = 2'd2;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE,
        S_SIN_Z, S_SIN_M1, S_SIN_W1, S_SIN_M2, S_SIN_W2, S_SIN_M3, S_SIN_W3,
        S_SIN_M4, S_SIN_W4,
        S_TGT_M, S_TGT_W, S_DRV_M1, S_DRV_W1, S_DRV_M2, S_DRV_W2,
        S_DOT_RD, S_DOT_MS, S_DOT_MC, S_DOT_END, S_AB,
        S_NRM_M1, S_NRM_W1, S_NRM_M2, S_NRM_W2, S_CHK,
        S_UPD_M, S_UPD_DIV, S_UPD_WAIT, S_UPD_MH, S_UPD_WH, S_UPD_ML, S_UPD_WL,
        S_OUT
    } t_state;

    // configuration
    logic [31:0]             r_phase_step;
    logic signed [SIG_W-1:0] r_goal_amp;
    logic [31:0]             r_goal_phase;
    logic [SIG_W-1:0]        r_step_size;
    logic [31:0]             r_adapt_start;

    // controller state
    t_state                  r_state;
    logic [31:0]             r_phase;
    logic [31:0]             r_tick;
    logic signed [WGT_W-1:0] r_ws;
    logic signed [WGT_W-1:0] r_wc;
    logic [ADDR_W-1:0]       r_head;
    logic [ADDR_W-1:0]       r_ptr;
    logic [ADDR_W-1:0]       r_tap;

    // per-tick working registers
    logic signed [SIG_W-1:0] r_fb;
    logic [1:0]              r_sel;
    logic [1:0]              r_quad;
    logic [30:0]             r_z;
    logic [30:0]             r_z2;
    logic [30:0]             r_t;
    logic signed [SIG_W-1:0] r_xs;
    logic signed [SIG_W-1:0] r_xc;
    logic signed [SIG_W-1:0] r_g;
    logic signed [SIG_W-1:0] r_err;
    logic signed [SIG_W-1:0] r_drive;
    logic signed [63:0]      r_dw;
    logic signed [ACC_W-1:0] r_acc_s;
    logic signed [ACC_W-1:0] r_acc_c;
    logic signed [SIG_W-1:0] r_a;
    logic signed [SIG_W-1:0] r_b;
    logic [NRM_W-1:0]        r_norm;
    logic                    r_wsel;
    logic                    r_neg;
    logic                    r_adapt;
    logic signed [RAT_W-1:0] r_ratio;

    // result register
    logic                    r_out_valid;
    logic signed [SIG_W-1:0] r_o_drive;
    logic signed [SIG_W-1:0] r_o_err;
    logic                    r_o_adapting;

    // tables: sine/cosine history side by side, and path coefficients
    logic [2*SIG_W-1:0]      r_hist_mem [TAPS];
    logic signed [SIG_W-1:0] r_coef_mem [TAPS];
    logic [2*SIG_W-1:0]      r_hist_q;
    logic signed [SIG_W-1:0] r_coef_q;

    logic                    hist_we;
    logic [ADDR_W-1:0]       hist_waddr;
    logic [2*SIG_W-1:0]      hist_wdata;
    logic                    coef_we;
    logic [ADDR_W-1:0]       coef_waddr;
    logic signed [SIG_W-1:0] coef_wdata;
    logic [ADDR_W-1:0]       coef_raddr;
    logic                    rd_en;
    logic                    load_ok;
    logic                    out_load;
    logic [ADDR_W-1:0]       head_dec;
    logic [ADDR_W-1:0]       ptr_inc;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    logic signed [63:0]       prod64;
    logic signed [ACC_W-1:0]  prod_acc;

    logic [31:0]             sin_phase;
    logic [31:0]             sin_sum;
    logic [21:0]             sin_mag;
    logic signed [SIG_W-1:0] sin_val;

    logic                    div_start;
    logic [DVD_W-1:0]        div_dividend;
    logic [DVD_W-1:0]        div_quot;
    t_div_status             div_stat;
    logic [NRM_W-1:0]        p_mag;
    logic [38:0]             q_clip;

    logic signed [SIG_W-1:0] filt;
    logic signed [WGT_W-1:0] w_cur;
    logic signed [63:0]      w_new64;
    logic signed [WGT_W-1:0] w_new;

    assign prod64   = mul_prod[63:0];
    // 24 by 24 product, sign extended into the accumulator
    assign prod_acc = ACC_W'($signed(mul_prod[2*SIG_W-1:0]));

    assign head_dec = (r_head == '0) ? LAST_TAP : r_head - 1'b1;
    assign ptr_inc  = (r_ptr == LAST_TAP) ? '0 : r_ptr + 1'b1;
    assign load_ok  = (32'(i_coef_index) < TAPS);

    // phase of the sine being built
    always_comb begin
        unique case (r_sel)
            SEL_SIN:  sin_phase = r_phase;
            SEL_COS:  sin_phase = r_phase + 32'h4000_0000;
            default:  sin_phase = r_phase + r_goal_phase;
        endcase
    end

    // final polynomial product back to q20 with rounding, sign from the quadrant
    assign sin_sum = mul_prod[61:30] + 32'd512;
    assign sin_mag = sin_sum[31:10];
    assign sin_val = r_quad[1] ? -$signed({2'b00, sin_mag}) : $signed({2'b00, sin_mag});

    assign filt  = r_wsel ? r_b : r_a;
    assign w_cur = r_wsel ? r_wc : r_ws;
    assign w_new64 = {{32{w_cur[WGT_W-1]}}, w_cur} + round_shr(r_dw + prod64, 12);
    assign w_new   = sat_s32(w_new64);

    // weight update ratio: magnitude into the divider, sign kept aside
    assign p_mag        = mul_prod[NRM_W-1] ? NRM_W'(-mul_prod[NRM_W-1:0])
                                            : mul_prod[NRM_W-1:0];
    assign div_dividend = {p_mag[46:0], 16'h0000};
    assign div_start    = (r_state == S_UPD_DIV);
    assign q_clip       = (div_quot > DVD_W'(RATIO_LIM)) ? RATIO_LIM : div_quot[38:0];

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SIN_M1: begin
                mul_a = {2'b00, r_z};
                mul_b = {2'b00, r_z};
            end
            S_SIN_M2: begin
                mul_a = {2'b00, SIN_C};
                mul_b = {2'b00, r_z2};
            end
            S_SIN_M3: begin
                mul_a = {2'b00, r_t};
                mul_b = {2'b00, r_z2};
            end
            S_SIN_M4: begin
                mul_a = {2'b00, r_t};
                mul_b = {2'b00, r_z};
            end
            S_TGT_M: begin
                mul_a = {{9{r_goal_amp[SIG_W-1]}}, r_goal_amp};
                mul_b = {{9{r_g[SIG_W-1]}}, r_g};
            end
            S_DRV_M1: begin
                mul_a = {r_ws[WGT_W-1], r_ws};
                mul_b = {{9{r_xs[SIG_W-1]}}, r_xs};
            end
            S_DRV_M2: begin
                mul_a = {r_wc[WGT_W-1], r_wc};
                mul_b = {{9{r_xc[SIG_W-1]}}, r_xc};
            end
            S_DOT_MS: begin
                mul_a = {{9{r_hist_q[2*SIG_W-1]}}, r_hist_q[2*SIG_W-1:SIG_W]};
                mul_b = {{9{r_coef_q[SIG_W-1]}}, r_coef_q};
            end
            S_DOT_MC: begin
                mul_a = {{9{r_hist_q[SIG_W-1]}}, r_hist_q[SIG_W-1:0]};
                mul_b = {{9{r_coef_q[SIG_W-1]}}, r_coef_q};
            end
            S_NRM_M1: begin
                mul_a = {{9{r_a[SIG_W-1]}}, r_a};
                mul_b = {{9{r_a[SIG_W-1]}}, r_a};
            end
            S_NRM_M2: begin
                mul_a = {{9{r_b[SIG_W-1]}}, r_b};
                mul_b = {{9{r_b[SIG_W-1]}}, r_b};
            end
            S_UPD_M: begin
                mul_a = {{9{filt[SIG_W-1]}}, filt};
                mul_b = {{9{r_err[SIG_W-1]}}, r_err};
            end
            S_UPD_MH: begin
                mul_a = {9'd0, r_step_size};
                mul_b = {{13{r_ratio[RAT_W-1]}}, r_ratio[RAT_W-1:20]};
            end
            S_UPD_ML: begin
                mul_a = {9'd0, r_step_size};
                mul_b = {13'd0, r_ratio[19:0]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    fxlms_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    fxlms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_norm),
        .o_quot     (div_quot),
        .o_stat     (div_stat)
    );

    // table ports
    assign hist_we    = (r_state == S_CLEAR) || (r_state == S_AB);
    assign hist_waddr = (r_state == S_CLEAR) ? r_ptr : head_dec;
    assign hist_wdata = (r_state == S_CLEAR) ? '0 : {r_xs, r_xc};
    assign coef_we    = (r_state == S_CLEAR) ||
                        ((r_state == S_IDLE) && i_in_valid && (i_action == ACT_LOAD) && load_ok);
    assign coef_waddr = (r_state == S_CLEAR) ? r_ptr : ADDR_W'(i_coef_index);
    assign coef_wdata = (r_state == S_CLEAR) ? '0 : i_coef_value;
    assign rd_en      = (r_state == S_DOT_RD) || (r_state == S_DOT_MC);
    // coefficients follow the tap number, history follows the circular pointer
    assign coef_raddr = ((r_state == S_DOT_RD) || (r_tap == LAST_TAP)) ? '0 : r_tap + 1'b1;

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[hist_waddr] <= hist_wdata;
        end
        if (coef_we) begin
            r_coef_mem[coef_waddr] <= coef_wdata;
        end
        if (rd_en) begin
            r_hist_q <= r_hist_mem[r_ptr];
            r_coef_q <= r_coef_mem[coef_raddr];
        end
    end

    // result register takes a word when it is empty or being drained
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_phase_step  <= '0;
            r_goal_amp    <= '0;
            r_goal_phase  <= '0;
            r_step_size   <= '0;
            r_adapt_start <= '0;
            r_phase       <= '0;
            r_tick        <= '0;
            r_ws          <= WS_RESET;
            r_wc          <= '0;
            r_head        <= '0;
            r_ptr         <= '0;
            r_tap         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data;
                    CFG_GOAL_AMP:    r_goal_amp    <= i_cfg_data[SIG_W-1:0];
                    CFG_GOAL_PHASE:  r_goal_phase  <= i_cfg_data;
                    CFG_STEP_SIZE:   r_step_size   <= i_cfg_data[SIG_W-1:0];
                    CFG_ADAPT_START: r_adapt_start <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_ptr <= ptr_inc;
                    if (r_ptr == LAST_TAP) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid && (i_action == ACT_TICK)) begin
                        r_fb    <= i_feedback;
                        r_sel   <= SEL_SIN;
                        r_ptr   <= r_head;
                        r_state <= S_SIN_Z;
                    end
                end
                // fold the phase into one quadrant, mirrored in odd quadrants
                S_SIN_Z: begin
                    r_quad  <= sin_phase[31:30];
                    r_z     <= sin_phase[30] ? (31'h4000_0000 - {1'b0, sin_phase[29:0]})
                                             : {1'b0, sin_phase[29:0]};
                    r_state <= S_SIN_M1;
                end
                S_SIN_M1: r_state <= S_SIN_W1;
                S_SIN_W1: begin
                    r_z2    <= mul_prod[60:30];
                    r_state <= S_SIN_M2;
                end
                S_SIN_M2: r_state <= S_SIN_W2;
                S_SIN_W2: begin
                    r_t     <= SIN_B - mul_prod[60:30];
                    r_state <= S_SIN_M3;
                end
                S_SIN_M3: r_state <= S_SIN_W3;
                S_SIN_W3: begin
                    r_t     <= SIN_A - mul_prod[60:30];
                    r_state <= S_SIN_M4;
                end
                S_SIN_M4: r_state <= S_SIN_W4;
                S_SIN_W4: begin
                    unique case (r_sel)
                        SEL_SIN: r_xs <= sin_val;
                        SEL_COS: r_xc <= sin_val;
                        default: r_g  <= sin_val;
                    endcase
                    if (r_sel == SEL_GOAL) begin
                        r_state <= S_TGT_M;
                    end else begin
                        r_sel   <= r_sel + 1'b1;
                        r_state <= S_SIN_Z;
                    end
                end
                // references done: advance phase and saturating tick count
                S_TGT_M: begin
                    r_phase <= r_phase + r_phase_step;
                    if (r_tick != 32'hFFFF_FFFF) begin
                        r_tick <= r_tick + 1'b1;
                    end
                    r_state <= S_TGT_W;
                end
                S_TGT_W: begin
                    r_err   <= sat_s24(round_shr(prod64, 20) - 64'(r_fb));
                    r_state <= S_DRV_M1;
                end
                S_DRV_M1: r_state <= S_DRV_W1;
                S_DRV_W1: begin
                    r_dw    <= prod64;
                    r_state <= S_DRV_M2;
                end
                S_DRV_M2: r_state <= S_DRV_W2;
                S_DRV_W2: begin
                    r_drive <= sat_s24(round_shr(r_dw + prod64, 24));
                    r_state <= S_DOT_RD;
                end
                // filtered references: two products per tap through the shared unit
                S_DOT_RD: begin
                    r_ptr   <= ptr_inc;
                    r_tap   <= '0;
                    r_acc_s <= '0;
                    r_acc_c <= '0;
                    r_state <= S_DOT_MS;
                end
                S_DOT_MS: begin
                    if (r_tap != '0) begin
                        r_acc_c <= r_acc_c + prod_acc;
                    end
                    r_state <= S_DOT_MC;
                end
                S_DOT_MC: begin
                    r_acc_s <= r_acc_s + prod_acc;
                    r_ptr   <= ptr_inc;
                    if (r_tap == LAST_TAP) begin
                        r_state <= S_DOT_END;
                    end else begin
                        r_tap   <= r_tap + 1'b1;
                        r_state <= S_DOT_MS;
                    end
                end
                S_DOT_END: begin
                    r_acc_c <= r_acc_c + prod_acc;
                    r_state <= S_AB;
                end
                // history push happens on the table port in this state
                S_AB: begin
                    r_a     <= sat_s24(round_shr(64'(r_acc_s), 20));
                    r_b     <= sat_s24(round_shr(64'(r_acc_c), 20));
                    r_head  <= head_dec;
                    r_state <= S_NRM_M1;
                end
                S_NRM_M1: r_state <= S_NRM_W1;
                S_NRM_W1: begin
                    r_norm  <= mul_prod[NRM_W-1:0];
                    r_state <= S_NRM_M2;
                end
                S_NRM_M2: r_state <= S_NRM_W2;
                S_NRM_W2: begin
                    r_norm  <= r_norm + mul_prod[NRM_W-1:0];
                    r_state <= S_CHK;
                end
                // adapt only once the tick count reaches the start count and with a nonzero norm
                S_CHK: begin
                    r_wsel <= 1'b0;
                    if ((r_tick >= r_adapt_start) && (r_norm != '0)) begin
                        r_adapt <= 1'b1;
                        r_state <= S_UPD_M;
                    end else begin
                        r_adapt <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_UPD_M: r_state <= S_UPD_DIV;
                S_UPD_DIV: begin
                    r_neg   <= mul_prod[NRM_W-1];
                    r_state <= S_UPD_WAIT;
                end
                S_UPD_WAIT: begin
                    if (div_stat.done) begin
                        r_ratio <= r_neg ? -$signed({1'b0, q_clip}) : $signed({1'b0, q_clip});
                        r_state <= S_UPD_MH;
                    end
                end
                S_UPD_MH: r_state <= S_UPD_WH;
                S_UPD_WH: begin
                    r_dw    <= prod64 <<< 20;
                    r_state <= S_UPD_ML;
                end
                S_UPD_ML: r_state <= S_UPD_WL;
                S_UPD_WL: begin
                    if (r_wsel) begin
                        r_wc    <= w_new;
                        r_state <= S_OUT;
                    end else begin
                        r_ws    <= w_new;
                        r_wsel  <= 1'b1;
                        r_state <= S_UPD_M;
                    end
                end
                // hand the word to the result register once it is free
                S_OUT: begin
                    if (out_load) begin
                        r_o_drive    <= r_drive;
                        r_o_err      <= r_err;
                        r_o_adapting <= r_adapt;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_drive       = r_o_drive;
    assign o_error_value = r_o_err;
    assign o_adapting    = r_o_adapting;

    `ASSERT_CLK(a_out_from_seq, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_OUT), "result without sequencer")
    `ASSERT_NEXT(a_dot_exit, i_clk, i_rst_n, (r_state == S_DOT_MC) && (r_tap == LAST_TAP), r_state == S_DOT_END, "dot loop did not finish")
    `ASSERT_CLK(a_div_wait, i_clk, i_rst_n, (r_state == S_UPD_WAIT) |-> (div_stat.busy || div_stat.done), "waiting on idle divider")

endmodule

@@ verif/tb_narrowband_fxlms_controller_unit.sv @@
// self-checking testbench of the narrowband filtered-x lms controller
`timescale 1ns / 1ps
module tb_narrowband_fxlms_controller_unit;
    import fxlms_pkg::*;

    localparam int NTAPS      = 300;
    localparam int IDLE_LIMIT = 20000;   // cycles with no accepted word at all
    localparam int HOLD_LEN   = 3000;    // long receiver hold-off
    localparam int SETTLE     = 1000;    // quiet cycles before config writes and at the end

    // one expected tick result
    typedef struct {
        logic signed [SIG_W-1:0] drive;
        logic signed [SIG_W-1:0] err;
        logic                    adapt;
    } t_tick_result;

    // fixed point model of the controller plus the queue of results it predicts
    class fxlms_tracker;
        bit [31:0]   phase_inc, goal_ofs, start_tick;
        int          goal_amp;
        longint      mu;
        int          sin_hist[NTAPS], cos_hist[NTAPS], path_tab[NTAPS];
        int          w_sin, w_cos;
        int unsigned ticks;
        bit [31:0]   phase;
        t_tick_result pending_ticks[$];
        int          mismatches, ticks_seen, loads_seen, adapt_seen;

        function void clear();
            phase_inc = 0; goal_ofs = 0; start_tick = 0; goal_amp = 0; mu = 0;
            foreach (sin_hist[k]) begin
                sin_hist[k] = 0; cos_hist[k] = 0; path_tab[k] = 0;
            end
            w_sin = 83886; w_cos = 0; ticks = 0; phase = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] data);
            case (idx)
                CFG_PHASE_STEP:  phase_inc = data;
                CFG_GOAL_AMP:    goal_amp = int'(signed'(data[23:0]));
                CFG_GOAL_PHASE:  goal_ofs = data;
                CFG_STEP_SIZE:   mu = longint'(data[23:0]);
                CFG_ADAPT_START: start_tick = data;
                default: ;
            endcase
        endfunction

        // polynomial sine, q20 out
        function int wave(bit [31:0] p);
            longint unsigned z, z2, t;
            int mag;
            z = longint'(p[29:0]);
            if (p[30]) z = 64'h4000_0000 - z;
            z2 = (z * z) >> 30;
            t = (64'(SIN_C) * z2) >> 30;
            t = 64'(SIN_B) - t;
            t = (t * z2) >> 30;
            t = 64'(SIN_A) - t;
            t = (t * z) >> 30;
            mag = int'((t + 512) >> 10);
            return p[31] ? -mag : mag;
        endfunction

        function longint rnd(longint v, int sh);
            return (v + (64'sd1 <<< (sh - 1))) >>> sh;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function int nudge(int w, longint f, longint e, longint norm);
            longint r;
            r = clip((f * e * 65536) / norm, -(64'sd1 <<< 38), 64'sd1 <<< 38);
            return int'(clip(longint'(w) + rnd(mu * r, 12), -(64'sd1 <<< 31),
                             (64'sd1 <<< 31) - 1));
        endfunction

        function void take_word(logic act, logic signed [23:0] fb,
                                logic [8:0] idx, logic signed [23:0] cv);
            int xs, xc, g;
            longint acc_s, acc_c, a, b, norm, e;
            t_tick_result res;
            if (act == ACT_LOAD) begin
                loads_seen++;
                // out of range indexes are dropped by the block
                if (idx < NTAPS) path_tab[idx] = int'(cv);
                return;
            end
            ticks_seen++;
            xs = wave(phase);
            xc = wave(phase + 32'h4000_0000);
            g  = wave(phase + goal_ofs);
            phase = phase + phase_inc;
            if (ticks != 32'hFFFF_FFFF) ticks++;
            e = clip(rnd(longint'(goal_amp) * g, 20) - longint'(fb), -8388608, 8388607);
            res.err = e[23:0];
            res.drive = 24'(clip(rnd(longint'(w_sin) * xs + longint'(w_cos) * xc, 24),
                                 -8388608, 8388607));
            acc_s = 0; acc_c = 0;
            for (int k = 0; k < NTAPS; k++) begin
                acc_s += longint'(sin_hist[k]) * path_tab[k];
                acc_c += longint'(cos_hist[k]) * path_tab[k];
            end
            a = clip(rnd(acc_s, 20), -8388608, 8388607);
            b = clip(rnd(acc_c, 20), -8388608, 8388607);
            for (int k = NTAPS - 1; k > 0; k--) begin
                sin_hist[k] = sin_hist[k-1]; cos_hist[k] = cos_hist[k-1];
            end
            sin_hist[0] = xs; cos_hist[0] = xc;
            norm = a * a + b * b;
            // zero norm skips the update
            res.adapt = (ticks >= start_tick) && (norm != 0);
            if (res.adapt) begin
                w_sin = nudge(w_sin, a, e, norm);
                w_cos = nudge(w_cos, b, e, norm);
            end
            pending_ticks.push_back(res);
        endfunction

        function void match_result(logic signed [23:0] drv, logic signed [23:0] err,
                                   logic adapt);
            t_tick_result x;
            if (pending_ticks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: drive %0d error %0d adapting %0d",
                             drv, err, adapt);
                return;
            end
            x = pending_ticks.pop_front();
            if (adapt) adapt_seen++;
            if (drv !== x.drive || err !== x.err || adapt !== x.adapt) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: drive %0d/%0d error %0d/%0d adapting %0d/%0d (exp/got)",
                             x.drive, drv, x.err, err, x.adapt, adapt);
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [31:0]             i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_action = ACT_TICK;
    logic signed [SIG_W-1:0] i_feedback = '0;
    logic [8:0]              i_coef_index = '0;
    logic signed [SIG_W-1:0] i_coef_value = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b1;
    logic signed [SIG_W-1:0] o_drive;
    logic signed [SIG_W-1:0] o_error_value;
    logic                    o_adapting;

    fxlms_tracker ctl = new();
    int  idle_cycles = 0;
    bit  hold_request = 0;   // asks the receiver for one long hold-off

    always #10 i_clk = ~i_clk;

    narrowband_fxlms_controller_unit #(.TAPS(NTAPS)) dut (.*);

    // accepted words on both channels, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                ctl.take_word(i_action, i_feedback, i_coef_index, i_coef_value);
            if (o_out_valid && !i_out_stall)
                ctl.match_result(o_drive, o_error_value, o_adapting);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver: random stalls, short mostly, a few long, one very long hold-off
    initial begin
        int run;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 0;
                i_out_stall = 1'b1;
                repeat (HOLD_LEN) @(negedge i_clk);
            end else if ($urandom_range(99) < 60) begin
                i_out_stall = 1'b0;
            end else begin
                i_out_stall = 1'b1;
                run = ($urandom_range(19) == 0) ? $urandom_range(200, 20) : $urandom_range(3, 1);
                repeat (run - 1) @(negedge i_clk);
            end
        end
    end

    // one register write; only called while no tick is in flight
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = data;
        ctl.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic program_all(bit [31:0] ps, bit [31:0] amp, bit [31:0] gp,
                               bit [31:0] mu, bit [31:0] start);
        write_reg(CFG_PHASE_STEP, ps);
        write_reg(CFG_GOAL_AMP, amp);
        write_reg(CFG_GOAL_PHASE, gp);
        write_reg(CFG_STEP_SIZE, mu);
        write_reg(CFG_ADAPT_START, start);
    endtask

    // offer one word and hold it until taken, then maybe leave a gap
    task automatic send_word(logic act, logic signed [23:0] fb, logic [8:0] idx,
                             logic signed [23:0] cv);
        int gap;
        i_in_valid = 1'b1;
        i_action = act; i_feedback = fb; i_coef_index = idx; i_coef_value = cv;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        gap = $urandom_range(99);
        gap = (gap < 65) ? 0 : (gap < 95) ? $urandom_range(3, 1) : $urandom_range(200, 20);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic tick(logic signed [23:0] fb);
        send_word(ACT_TICK, fb, 9'($urandom), 24'($urandom));
    endtask

    task automatic load(logic [8:0] idx, logic signed [23:0] cv);
        send_word(ACT_LOAD, 24'($urandom), idx, cv);
    endtask

    // sender waits until every tick result is back, then lets loads settle
    task automatic drain();
        i_in_valid = 1'b0;
        while (ctl.pending_ticks.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic random_words(int count, bit early_hold);
        for (int n = 0; n < count; n++) begin
            if (early_hold && n == 20) hold_request = 1;
            if ($urandom_range(99) < 15)
                load(($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(319)),
                     24'($urandom));
            else if ($urandom_range(3) == 0)
                tick(24'(int'($urandom_range(4000)) - 2000));
            else
                tick(24'($urandom));
        end
    endtask

    initial begin
        ctl.clear();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes of each field, loads in and out of range
        program_all(32'h1000_0000, 32'h007F_FFFF, 32'h4000_0000, 32'h0010_0000, 32'd0);
        tick(24'sh7FFFFF);
        tick(24'sh800000);
        load(9'd0, 24'sh400000);
        load(9'd1, 24'sh800000);
        load(9'd299, 24'sh7FFFFF);
        load(9'd300, 24'sh7FFFFF);     // dropped
        load(9'd511, 24'sh800000);     // dropped
        tick(24'sd0);
        tick(-24'sd1);
        tick(24'sh7FFFFF);
        tick(24'sh800000);
        load(9'd2, 24'sh7FFFFF);
        for (int n = 0; n < 10; n++) tick(24'($urandom));
        drain();

        // extremes: largest phase step, most negative target, full step, never adapt
        program_all(32'hFFFF_FFFF, 32'h0080_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFFFF_FFFF);
        random_words(90, 1);
        drain();

        // random setting, adaptation starting soon
        program_all($urandom, $urandom, $urandom, $urandom_range(32'h00FF_FFFF),
                    $urandom_range(400));
        random_words(100, 0);
        drain();

        // everything at zero
        program_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        random_words(60, 0);
        drain();

        // large step, full amplitude, adapt right away
        program_all($urandom, 32'h007F_FFFF, $urandom, 32'h00FF_FFFF, 32'd0);
        random_words(130, 0);
        drain();

        $display("covered %0d ticks and %0d coefficient loads over five register settings,",
                 ctl.ticks_seen, ctl.loads_seen);
        $display("%0d results came back with adaptation on", ctl.adapt_seen);
        if (ctl.mismatches == 0 && ctl.pending_ticks.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", ctl.mismatches,
                     ctl.pending_ticks.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
